>>> rtl/core/nldm_table_bilinear_interp_unit_defines.svh
// Assertion macros shared by the NLDM interpolation unit RTL.
// No dependencies; included by the files that carry assertions.
`ifndef NLDM_TABLE_BILINEAR_INTERP_UNIT_DEFINES_SVH
`define NLDM_TABLE_BILINEAR_INTERP_UNIT_DEFINES_SVH

// same-cycle implication
`define NTI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nti: assertion failed");

// next-cycle implication
`define NTI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nti: assertion failed");

`endif

>>> rtl/core/nti_pkg.sv
// Package for the NLDM interpolation unit: sizes, codes, struct types, helpers.
// No dependencies.
package nti_pkg;

   localparam int AXIS_POINTS = 7;
   localparam int AX_IDX_W    = 3;
   localparam int TABLE_SIZE  = AXIS_POINTS * AXIS_POINTS;
   localparam int TABLE_COUNT = 18;
   localparam int TB_DEPTH    = TABLE_COUNT * TABLE_SIZE;
   localparam int TB_ADDR_W   = 10;
   localparam int VAL_W       = 24;

   // datapath widths
   localparam int STG_W  = 37;   // load-stage value after clamp
   localparam int DIFF_W = 38;   // difference of two stage values
   localparam int MUL_W  = 24;   // |q - p_lo| and |p_hi - p_lo|
   localparam int DEN_W  = 25;   // signed axis differences, also 2*|d|
   localparam int PROD_W = 61;
   localparam int NUM_W  = 63;
   localparam int QUOT_W = 64;

   localparam logic [1:0] REQ_WR_LOAD  = 2'd0;
   localparam logic [1:0] REQ_WR_TRANS = 2'd1;
   localparam logic [1:0] REQ_WR_TABLE = 2'd2;
   localparam logic [1:0] REQ_QUERY    = 2'd3;

   localparam logic [1:0] GATE_NAND2   = 2'd2;
   localparam logic [1:0] TKIND_NONE   = 2'd3;

   localparam logic AX_LOAD  = 1'b0;
   localparam logic AX_TRANS = 1'b1;

   typedef struct packed {
      logic                   wr_en;
      logic [1:0]             wr_tgt;
      logic [AX_IDX_W-1:0]    wr_ax_idx;
      logic [TB_ADDR_W-1:0]   wr_tb_addr;
      logic [VAL_W-1:0]       wr_data;
      logic                   ax_sel;
      logic [AX_IDX_W-1:0]    ax_addr;
      logic [TB_ADDR_W-1:0]   tb_addr;
   } st_cmd_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] mult_a;
      logic signed [DEN_W-1:0]  mult_b;
      logic signed [DEN_W-1:0]  divisor;
   } md_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [QUOT_W-1:0] quot;
   } md_rsp_type;

   function automatic logic [TB_ADDR_W-1:0] tb_base(input logic [1:0] gate,
                                                     input logic [1:0] tkind,
                                                     input logic       rise);
      logic [1:0] g;
      logic [4:0] tsel;
      g    = (gate > GATE_NAND2) ? GATE_NAND2 : gate;
      tsel = ({3'b0, g} * 5'd3 + {3'b0, tkind}) * 5'd2 + {4'b0, rise};
      return {5'b0, tsel} * TB_ADDR_W'(TABLE_SIZE);
   endfunction

   function automatic logic [TB_ADDR_W-1:0] cell_off(input logic [AX_IDX_W-1:0] row,
                                                      input logic [AX_IDX_W-1:0] col);
      return TB_ADDR_W'(row) * TB_ADDR_W'(AXIS_POINTS) + TB_ADDR_W'(col);
   endfunction

   function automatic logic signed [STG_W-1:0] stage_clamp(input logic signed [QUOT_W-1:0] v);
      logic [QUOT_W-STG_W:0] hi;
      hi = v[QUOT_W-1:STG_W-1];
      if (hi == '0 || hi == '1)
         return v[STG_W-1:0];
      else if (v[QUOT_W-1])
         return {1'b1, {(STG_W-1){1'b0}}};
      else
         return {1'b0, {(STG_W-1){1'b1}}};
   endfunction

endpackage

>>> rtl/core/nti_req_if.sv
// Request channel of the NLDM interpolation unit: valid/ready plus one request beat.
// Depends on nti_pkg.
interface nti_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic [1:0]                gate_kind;
   logic [1:0]                table_kind;
   logic                      rise_sel;
   logic [2:0]                row_index;
   logic [2:0]                col_index;
   logic [nti_pkg::VAL_W-1:0] write_value;
   logic [nti_pkg::VAL_W-1:0] load_value;
   logic [nti_pkg::VAL_W-1:0] transition_value;

   modport source (output valid, req_type, gate_kind, table_kind, rise_sel, row_index,
                   col_index, write_value, load_value, transition_value, input ready);
   modport sink (input valid, req_type, gate_kind, table_kind, rise_sel, row_index,
                 col_index, write_value, load_value, transition_value, output ready);
endinterface

>>> rtl/core/nti_rsp_if.sv
// Response channel of the NLDM interpolation unit: valid/ready plus one result beat.
// Depends on nti_pkg.
interface nti_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [nti_pkg::VAL_W-1:0] result_value;
   logic                      saturated;

   modport source (output valid, result_value, saturated, input ready);
   modport sink (input valid, result_value, saturated, output ready);
endinterface

>>> rtl/core/nti_store.sv
// Breakpoint axes and timing table storage, one write and one registered read each.
// Depends on nti_pkg.
module nti_store (
   input  logic                          clock,
   input  nti_pkg::st_cmd_type           cmd,
   output logic [nti_pkg::VAL_W-1:0]     ax_rdata,
   output logic [nti_pkg::VAL_W-1:0]     tb_rdata
);
   import nti_pkg::*;

   logic [VAL_W-1:0] load_axis [AXIS_POINTS];
   logic [VAL_W-1:0] trans_axis [AXIS_POINTS];
   logic [VAL_W-1:0] table_mem [TB_DEPTH];
   logic [VAL_W-1:0] ax_rd_ff;
   logic [VAL_W-1:0] tb_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_tgt == REQ_WR_LOAD) begin
         load_axis[cmd.wr_ax_idx] <= cmd.wr_data;
      end
      if (cmd.wr_en && cmd.wr_tgt == REQ_WR_TRANS) begin
         trans_axis[cmd.wr_ax_idx] <= cmd.wr_data;
      end
      ax_rd_ff <= (cmd.ax_sel == AX_TRANS) ? trans_axis[cmd.ax_addr] : load_axis[cmd.ax_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_tgt == REQ_WR_TABLE) begin
         table_mem[cmd.wr_tb_addr] <= cmd.wr_data;
      end
      tb_rd_ff <= table_mem[cmd.tb_addr];
   end

   assign ax_rdata = ax_rd_ff;
   assign tb_rdata = tb_rd_ff;
endmodule

>>> rtl/core/nti_muldiv.sv
// Shared sequential unit: round-to-nearest of (a * b) / d, shift-add multiply
// then restoring divide, one bit per cycle. Depends on nti_pkg and the defines header.
`include "nldm_table_bilinear_interp_unit_defines.svh"

module nti_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  nti_pkg::md_req_type md_req,
   output nti_pkg::md_rsp_type md_rsp
);
   import nti_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [1:0]               ph_ff, ph_in;
   logic [5:0]               cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic [PROD_W-1:0]        mcand_ff, mcand_in;
   logic [MUL_W-1:0]         mplier_ff, mplier_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [MUL_W-1:0]         ud_ff, ud_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic signed [QUOT_W-1:0] quot_ff, quot_in;

   logic [DIFF_W-1:0] a_abs;
   logic [DEN_W-1:0]  b_abs;
   logic [DEN_W-1:0]  d_abs;
   logic [PROD_W-1:0] acc_step;
   logic [DEN_W-1:0]  den;
   logic [DEN_W:0]    rem_sh;
   logic              take;
   logic [DEN_W:0]    rem_sub;
   logic [QUOT_W-1:0] qpos;

   always_comb begin
      a_abs    = md_req.mult_a[DIFF_W-1] ? (~md_req.mult_a + 1'b1) : md_req.mult_a;
      b_abs    = md_req.mult_b[DEN_W-1] ? (~md_req.mult_b + 1'b1) : md_req.mult_b;
      d_abs    = md_req.divisor[DEN_W-1] ? (~md_req.divisor + 1'b1) : md_req.divisor;
      acc_step = mplier_ff[0] ? (acc_ff + mcand_ff) : acc_ff;
      den      = {ud_ff, 1'b0};
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      take     = (rem_sh >= {1'b0, den});
      rem_sub  = take ? (rem_sh - {1'b0, den}) : rem_sh;
      qpos     = {1'b0, num_ff[NUM_W-2:0], take};

      ph_in     = ph_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      ud_in     = ud_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;

      case (ph_ff)
         PH_IDLE: begin
            if (md_req.start) begin
               neg_in    = md_req.mult_a[DIFF_W-1] ^ md_req.mult_b[DEN_W-1]
                         ^ md_req.divisor[DEN_W-1];
               mcand_in  = {{(PROD_W-DIFF_W+1){1'b0}}, a_abs[DIFF_W-2:0]};
               mplier_in = b_abs[MUL_W-1:0];
               ud_in     = d_abs[MUL_W-1:0];
               acc_in    = '0;
               cnt_in    = '0;
               ph_in     = PH_MUL;
            end
         end
         PH_MUL: begin
            acc_in    = acc_step;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MUL_W-1:1]};
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_W-1)) begin
               // numerator 2|n| + |d|, so the floor below rounds half away from zero
               num_in = {1'b0, acc_step, 1'b0} + NUM_W'(ud_ff);
               rem_in = '0;
               cnt_in = '0;
               ph_in  = PH_DIV;
            end
         end
         PH_DIV: begin
            rem_in = rem_sub[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], take};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NUM_W-1)) begin
               quot_in = neg_ff ? -$signed(qpos) : $signed(qpos);
               ph_in   = PH_DONE;
            end
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
      end else begin
         ph_ff <= ph_in;
      end
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      ud_ff     <= ud_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
   end

   assign md_rsp.done = (ph_ff == PH_DONE);
   assign md_rsp.quot = quot_ff;

   `NTI_ASSERT_IMP(a_start_idle, clock, reset, md_req.start, ph_ff == PH_IDLE)
   `NTI_ASSERT_NXT(a_done_pulse, clock, reset, md_rsp.done, ph_ff == PH_IDLE)
   `NTI_ASSERT_IMP(a_rem_below_den, clock, reset, ph_ff == PH_DIV, rem_ff < den)
endmodule

>>> rtl/core/nldm_table_bilinear_interp_unit.sv
// NLDM 7x7 bilinear table interpolation unit, top level with query sequencer.
// Depends on nti_pkg, nti_req_if, nti_rsp_if, nti_store, nti_muldiv, defines header.
//
// Usage:
//  req_chan carries one request per beat: load breakpoint, transition
//  breakpoint or table word writes, and queries (load, transition).
//  Writes complete in the beat they are accepted and give no response.
//  A query gives exactly one rsp_chan beat: result_value (unsigned Q4.20,
//  clamped at zero) and saturated.
//  A query walks each axis through one registered read port, then runs
//  three line interpolations through the shared multiply/divide unit,
//  which multiplies and then divides; exact breakpoint hits skip the
//  multiply and the divide. One query is in flight at a time; req_ready is
//  high only while the sequencer is idle.
//  A finished result sits in the response register; the next request is
//  accepted while it waits, and a later result holds until rsp_ready.
//  Reset (synchronous) clears the sequencer and the response valid; axes
//  and tables are undefined until written.
`include "nldm_table_bilinear_interp_unit_defines.svh"

module nldm_table_bilinear_interp_unit (
   input logic       clock,
   input logic       reset,
   nti_req_if.sink   req_chan,
   nti_rsp_if.source rsp_chan
);
   import nti_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_AX_RD0  = 4'd1;
   localparam logic [3:0] ST_AX_RDL  = 4'd2;
   localparam logic [3:0] ST_AX_CHK  = 4'd3;
   localparam logic [3:0] ST_SC_ADR  = 4'd4;
   localparam logic [3:0] ST_SC_DAT  = 4'd5;
   localparam logic [3:0] ST_P_LO    = 4'd6;
   localparam logic [3:0] ST_P_HI    = 4'd7;
   localparam logic [3:0] ST_P_CAP   = 4'd8;
   localparam logic [3:0] ST_TB_LO   = 4'd9;
   localparam logic [3:0] ST_TB_HI   = 4'd10;
   localparam logic [3:0] ST_TB_CAP  = 4'd11;
   localparam logic [3:0] ST_LN_EVAL = 4'd12;
   localparam logic [3:0] ST_LN_WAIT = 4'd13;
   localparam logic [3:0] ST_LN_DONE = 4'd14;
   localparam logic [3:0] ST_FIN     = 4'd15;

   localparam logic [AX_IDX_W-1:0] IDX_LAST = AX_IDX_W'(AXIS_POINTS - 1);
   localparam logic [AX_IDX_W-1:0] IDX_PEN  = AX_IDX_W'(AXIS_POINTS - 2);

   st_cmd_type  st_cmd;
   md_req_type  md_req;
   md_rsp_type  md_rsp;
   logic [VAL_W-1:0] ax_rd;
   logic [VAL_W-1:0] tb_rd;

   logic [3:0]              state_ff, state_in;
   logic                    axis_ff, axis_in;
   logic [1:0]              stg_ff, stg_in;
   logic [AX_IDX_W-1:0]     cnt_ff, cnt_in;
   logic [AX_IDX_W-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [AX_IDX_W-1:0]     y1_ff, y1_in, y2_ff, y2_in, x1_ff, x1_in, x2_ff, x2_in;
   logic [VAL_W-1:0]        load_ff, load_in, trans_ff, trans_in;
   logic [TB_ADDR_W-1:0]    base_ff, base_in;
   logic [VAL_W-1:0]        a0_ff, a0_in, prev_ff, prev_in, plo_ff, plo_in;
   logic [VAL_W-1:0]        lplo_ff, lplo_in, lphi_ff, lphi_in;
   logic [VAL_W-1:0]        tplo_ff, tplo_in, tphi_ff, tphi_in;
   logic signed [STG_W-1:0] t1_ff, t1_in, vlo_ff, vlo_in, vhi_ff, vhi_in;
   logic [VAL_W-1:0]        fin_val_ff, fin_val_in;
   logic                    fin_sat_ff, fin_sat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        rsp_val_ff, rsp_val_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   logic                    req_fire;
   logic                    rsp_fire;
   logic [VAL_W-1:0]        q_cur;
   logic [AX_IDX_W-1:0]     row_cur;
   logic [AX_IDX_W-1:0]     l_lo, l_hi;
   logic [VAL_W-1:0]        l_plo, l_phi, l_q;
   logic signed [DEN_W-1:0] l_d, l_qd;
   logic signed [QUOT_W-1:0] vlo_ext, r_sum;
   logic signed [QUOT_W-1:0] r_line;
   logic                    r_ready;
   logic signed [STG_W-1:0] r_clamp;

   nti_store u_store (
      .clock    (clock),
      .cmd      (st_cmd),
      .ax_rdata (ax_rd),
      .tb_rdata (tb_rd)
   );

   nti_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;

   // storage port
   always_comb begin
      st_cmd.wr_en      = 1'b0;
      st_cmd.wr_tgt     = req_chan.req_type;
      st_cmd.wr_ax_idx  = req_chan.row_index;
      st_cmd.wr_tb_addr = tb_base(req_chan.gate_kind, req_chan.table_kind, req_chan.rise_sel)
                        + cell_off(req_chan.row_index, req_chan.col_index);
      st_cmd.wr_data    = req_chan.write_value;
      if (req_fire) begin
         case (req_chan.req_type)
            REQ_WR_LOAD, REQ_WR_TRANS: begin
               st_cmd.wr_en = (req_chan.row_index < AX_IDX_W'(AXIS_POINTS));
            end
            REQ_WR_TABLE: begin
               st_cmd.wr_en = (req_chan.table_kind != TKIND_NONE)
                            && (req_chan.row_index < AX_IDX_W'(AXIS_POINTS))
                            && (req_chan.col_index < AX_IDX_W'(AXIS_POINTS));
            end
            default: begin
               st_cmd.wr_en = 1'b0;
            end
         endcase
      end

      st_cmd.ax_sel = axis_ff;
      case (state_ff)
         ST_AX_RDL: st_cmd.ax_addr = IDX_LAST;
         ST_SC_ADR: st_cmd.ax_addr = cnt_ff;
         ST_P_LO:   st_cmd.ax_addr = lo_ff;
         ST_P_HI:   st_cmd.ax_addr = hi_ff;
         default:   st_cmd.ax_addr = '0;
      endcase

      row_cur        = (stg_ff == 2'd0) ? x1_ff : x2_ff;
      st_cmd.tb_addr = base_ff + cell_off(row_cur, (state_ff == ST_TB_HI) ? y2_ff : y1_ff);
   end

   // line parameters: load axis for the two row passes, transition axis last
   always_comb begin
      q_cur = (axis_ff == AX_TRANS) ? trans_ff : load_ff;
      if (stg_ff == 2'd2) begin
         l_lo = x1_ff; l_hi = x2_ff; l_plo = tplo_ff; l_phi = tphi_ff; l_q = trans_ff;
      end else begin
         l_lo = y1_ff; l_hi = y2_ff; l_plo = lplo_ff; l_phi = lphi_ff; l_q = load_ff;
      end
      l_d     = $signed({1'b0, l_phi}) - $signed({1'b0, l_plo});
      l_qd    = $signed({1'b0, l_q}) - $signed({1'b0, l_plo});
      vlo_ext = QUOT_W'(vlo_ff);
      r_sum   = vlo_ext + md_rsp.quot;

      md_req.start   = 1'b0;
      md_req.mult_a  = DIFF_W'(vhi_ff) - DIFF_W'(vlo_ff);
      md_req.mult_b  = l_qd;
      md_req.divisor = l_d;

      r_ready = 1'b0;
      r_line  = vlo_ext;
      if (state_ff == ST_LN_EVAL) begin
         if (l_lo == l_hi) begin
            r_ready = 1'b1;
         end else if (l_d == '0) begin
            // flat edge pair: take the entry on the query's side
            r_ready = 1'b1;
            r_line  = (l_q <= l_plo) ? vlo_ext : QUOT_W'(vhi_ff);
         end else begin
            md_req.start = 1'b1;
         end
      end else if (state_ff == ST_LN_WAIT && md_rsp.done) begin
         r_ready = 1'b1;
         r_line  = r_sum;
      end
      r_clamp = stage_clamp(r_line);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      stg_in       = stg_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      load_in      = load_ff;
      trans_in     = trans_ff;
      base_in      = base_ff;
      a0_in        = a0_ff;
      prev_in      = prev_ff;
      plo_in       = plo_ff;
      lplo_in      = lplo_ff;
      lphi_in      = lphi_ff;
      tplo_in      = tplo_ff;
      tphi_in      = tphi_ff;
      t1_in        = t1_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      fin_val_in   = fin_val_ff;
      fin_sat_in   = fin_sat_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.req_type == REQ_QUERY) begin
               load_in  = req_chan.load_value;
               trans_in = req_chan.transition_value;
               base_in  = tb_base(req_chan.gate_kind, req_chan.table_kind, req_chan.rise_sel);
               axis_in  = AX_LOAD;
               if (req_chan.table_kind == TKIND_NONE) begin
                  fin_val_in = '0;
                  fin_sat_in = 1'b0;
                  state_in   = ST_FIN;
               end else begin
                  state_in = ST_AX_RD0;
               end
            end
         end
         ST_AX_RD0: state_in = ST_AX_RDL;
         ST_AX_RDL: begin
            a0_in    = ax_rd;
            state_in = ST_AX_CHK;
         end
         ST_AX_CHK: begin
            if (q_cur < a0_ff) begin
               lo_in = '0; hi_in = AX_IDX_W'(1); state_in = ST_P_LO;
            end else if (q_cur > ax_rd) begin
               lo_in = IDX_PEN; hi_in = IDX_LAST; state_in = ST_P_LO;
            end else begin
               cnt_in   = '0;
               state_in = ST_SC_ADR;
            end
         end
         ST_SC_ADR: state_in = ST_SC_DAT;
         ST_SC_DAT: begin
            // ax_rd is axis[cnt], prev_ff is axis[cnt-1]
            prev_in  = ax_rd;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_SC_ADR;
            if (cnt_ff != '0) begin
               if (q_cur == prev_ff) begin
                  lo_in = cnt_ff - 1'b1; hi_in = cnt_ff - 1'b1; state_in = ST_P_LO;
               end else if (q_cur == ax_rd) begin
                  lo_in = cnt_ff; hi_in = cnt_ff; state_in = ST_P_LO;
               end else if (q_cur > prev_ff && q_cur < ax_rd) begin
                  lo_in = cnt_ff - 1'b1; hi_in = cnt_ff; state_in = ST_P_LO;
               end else if (cnt_ff == IDX_LAST) begin
                  // axis not ascending: fall back to an exact hit on the first point
                  lo_in = '0; hi_in = '0; state_in = ST_P_LO;
               end
            end
         end
         ST_P_LO: state_in = ST_P_HI;
         ST_P_HI: begin
            plo_in   = ax_rd;
            state_in = ST_P_CAP;
         end
         ST_P_CAP: begin
            if (axis_ff == AX_LOAD) begin
               y1_in = lo_ff; y2_in = hi_ff; lplo_in = plo_ff; lphi_in = ax_rd;
               axis_in  = AX_TRANS;
               state_in = ST_AX_RD0;
            end else begin
               x1_in = lo_ff; x2_in = hi_ff; tplo_in = plo_ff; tphi_in = ax_rd;
               stg_in   = 2'd0;
               state_in = ST_TB_LO;
            end
         end
         ST_TB_LO: state_in = ST_TB_HI;
         ST_TB_HI: begin
            vlo_in   = STG_W'(tb_rd);
            state_in = ST_TB_CAP;
         end
         ST_TB_CAP: begin
            vhi_in   = STG_W'(tb_rd);
            state_in = ST_LN_EVAL;
         end
         ST_LN_EVAL, ST_LN_WAIT: begin
            if (r_ready) begin
               state_in = ST_LN_DONE;
            end else if (state_ff == ST_LN_EVAL) begin
               state_in = ST_LN_WAIT;
            end
         end
         ST_LN_DONE: begin
            case (stg_ff)
               2'd0: begin
                  t1_in    = vlo_ff;
                  stg_in   = 2'd1;
                  state_in = ST_TB_LO;
               end
               2'd1: begin
                  vlo_in   = t1_ff;
                  vhi_in   = vlo_ff;
                  stg_in   = 2'd2;
                  state_in = ST_LN_EVAL;
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = fin_val_ff;
               rsp_sat_in   = fin_sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // line result lands in vlo (clamped) for the row passes, in fin for the last
      if (r_ready) begin
         if (stg_ff == 2'd2) begin
            if (r_line[QUOT_W-1]) begin
               fin_val_in = '0; fin_sat_in = 1'b0;
            end else if (r_line[QUOT_W-2:VAL_W] != '0) begin
               fin_val_in = '1; fin_sat_in = 1'b1;
            end else begin
               fin_val_in = r_line[VAL_W-1:0]; fin_sat_in = 1'b0;
            end
         end else begin
            vlo_in = r_clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff    <= axis_in;
      stg_ff     <= stg_in;
      cnt_ff     <= cnt_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      y1_ff      <= y1_in;
      y2_ff      <= y2_in;
      x1_ff      <= x1_in;
      x2_ff      <= x2_in;
      load_ff    <= load_in;
      trans_ff   <= trans_in;
      base_ff    <= base_in;
      a0_ff      <= a0_in;
      prev_ff    <= prev_in;
      plo_ff     <= plo_in;
      lplo_ff    <= lplo_in;
      lphi_ff    <= lphi_in;
      tplo_ff    <= tplo_in;
      tphi_ff    <= tphi_in;
      t1_ff      <= t1_in;
      vlo_ff     <= vlo_in;
      vhi_ff     <= vhi_in;
      fin_val_ff <= fin_val_in;
      fin_sat_ff <= fin_sat_in;
      rsp_val_ff <= rsp_val_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_val_ff;
   assign rsp_chan.saturated    = rsp_sat_ff;

   `NTI_ASSERT_IMP(a_pair_order, clock, reset, state_ff == ST_P_LO, (lo_ff <= hi_ff) && (hi_ff <= IDX_LAST))
   `NTI_ASSERT_IMP(a_sat_value, clock, reset, rsp_valid_ff && rsp_sat_ff, rsp_val_ff == '1)
   `NTI_ASSERT_NXT(a_wait_done, clock, reset, (state_ff == ST_LN_WAIT) && md_rsp.done, state_ff == ST_LN_DONE)
   `NTI_ASSERT_IMP(a_md_idle_start, clock, reset, md_req.start, state_ff == ST_LN_EVAL)
endmodule

>>> bench/nti_interp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the NLDM interpolation unit: mirrors axes and tables from request beats,
// predicts each query result and compares it with the response beats.
// Depends on nti_pkg, nti_req_if, nti_rsp_if.
module nti_interp_checker (
   input  logic clock,
   input  logic reset,
   nti_req_if   req_mon,
   nti_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   lookups_outstanding
);
   import nti_pkg::*;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             sat;
   } lookup_type;

   localparam longint STAGE_MAX = (64'sd1 <<< 36) - 1;
   localparam longint STAGE_MIN = -(64'sd1 <<< 36);

   logic [AXIS_POINTS-1:0][VAL_W-1:0] load_bp;
   logic [AXIS_POINTS-1:0][VAL_W-1:0] trans_bp;
   logic [VAL_W-1:0]                  tables [TB_DEPTH];
   lookup_type                        pending_lookups [$];
   int                                errors;
   int                                pending_cnt;

   assign mismatch_count      = errors;
   assign lookups_outstanding = pending_cnt;

   function automatic longint div_nearest(input longint n, input longint d);
      longint unsigned un, ud, q;
      un = (n < 0) ? longint'(-n) : n;
      ud = (d < 0) ? longint'(-d) : d;
      q  = (2 * un + ud) / (2 * ud);
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   // first deciding segment; out-of-range queries take the edge pair
   function automatic void bracket(input logic [AXIS_POINTS-1:0][VAL_W-1:0] ax,
                                   input longint q, output int lo, output int hi);
      lo = 0;
      hi = 0;
      if (q < longint'(ax[0])) begin
         hi = 1;
      end else if (q > longint'(ax[AXIS_POINTS-1])) begin
         lo = AXIS_POINTS - 2;
         hi = AXIS_POINTS - 1;
      end else begin
         for (int i = AXIS_POINTS - 2; i >= 0; i--) begin
            if (q == longint'(ax[i])) begin
               lo = i; hi = i;
            end else if (q == longint'(ax[i+1])) begin
               lo = i + 1; hi = i + 1;
            end else if (q > longint'(ax[i]) && q < longint'(ax[i+1])) begin
               lo = i; hi = i + 1;
            end
         end
      end
   endfunction

   function automatic longint lerp(input longint v_lo, input longint v_hi,
                                   input longint p_lo, input longint p_hi,
                                   input longint q, input int lo, input int hi);
      if (lo == hi) return v_lo;
      if (p_hi == p_lo) return (q <= p_lo) ? v_lo : v_hi;
      return v_lo + div_nearest((v_hi - v_lo) * (q - p_lo), p_hi - p_lo);
   endfunction

   function automatic longint clamp_stage(input longint v);
      if (v < STAGE_MIN) return STAGE_MIN;
      if (v > STAGE_MAX) return STAGE_MAX;
      return v;
   endfunction

   function automatic int table_base(input logic [1:0] gate, input logic [1:0] tk,
                                     input logic rise);
      int g;
      g = (gate > GATE_NAND2) ? int'(GATE_NAND2) : int'(gate);
      return ((g * 3 + int'(tk)) * 2 + int'(rise)) * TABLE_SIZE;
   endfunction

   function automatic lookup_type interp_lookup(input logic [1:0] gate, input logic [1:0] tk,
                                                input logic rise, input longint ld,
                                                input longint tr);
      lookup_type r;
      int         b, y1, y2, x1, x2;
      longint     t1, t2, v;
      r = '0;
      if (tk == TKIND_NONE) return r;
      b = table_base(gate, tk, rise);
      bracket(load_bp, ld, y1, y2);
      bracket(trans_bp, tr, x1, x2);
      t1 = lerp(tables[b + x1*AXIS_POINTS + y1], tables[b + x1*AXIS_POINTS + y2],
                load_bp[y1], load_bp[y2], ld, y1, y2);
      t2 = lerp(tables[b + x2*AXIS_POINTS + y1], tables[b + x2*AXIS_POINTS + y2],
                load_bp[y1], load_bp[y2], ld, y1, y2);
      v = lerp(clamp_stage(t1), clamp_stage(t2), trans_bp[x1], trans_bp[x2], tr, x1, x2);
      if (v > 64'sh00FF_FFFF) begin
         r.value = '1;
         r.sat   = 1'b1;
      end else if (v >= 0) begin
         r.value = v[VAL_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_type got, want;
      if (reset) begin
         errors = 0;
         pending_lookups.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.req_type)
               REQ_WR_LOAD:
                  if (req_mon.row_index < AXIS_POINTS)
                     load_bp[req_mon.row_index] = req_mon.write_value;
               REQ_WR_TRANS:
                  if (req_mon.row_index < AXIS_POINTS)
                     trans_bp[req_mon.row_index] = req_mon.write_value;
               REQ_WR_TABLE:
                  if (req_mon.table_kind != TKIND_NONE && req_mon.row_index < AXIS_POINTS
                      && req_mon.col_index < AXIS_POINTS)
                     tables[table_base(req_mon.gate_kind, req_mon.table_kind,
                                       req_mon.rise_sel)
                            + req_mon.row_index*AXIS_POINTS + req_mon.col_index]
                        = req_mon.write_value;
               default:
                  pending_lookups = {pending_lookups, interp_lookup(req_mon.gate_kind,
                     req_mon.table_kind, req_mon.rise_sel, req_mon.load_value,
                     req_mon.transition_value)};
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.value = rsp_mon.result_value;
            got.sat   = rsp_mon.saturated;
            if (pending_lookups.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result beat: value %h sat %b", got.value, got.sat);
            end else begin
               want = pending_lookups.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("result mismatch: expected value %h sat %b, got value %h sat %b",
                              want.value, want.sat, got.value, got.sat);
               end
            end
         end
      end
      pending_cnt = pending_lookups.size();
   end
endmodule

>>> bench/nldm_table_bilinear_interp_unit_test.sv
`timescale 1ns / 1ps
// Top of the NLDM interpolation unit bench: clock, reset, request and response traffic.
// Depends on nti_pkg, the channel interfaces, the unit and nti_interp_checker.
module nldm_table_bilinear_interp_unit_test;
   import nti_pkg::*;

   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 1500000;

   logic clock;
   logic reset;
   int   fails;
   int   outstanding;
   int   items_sent;
   int   cycles;
   bit   calm;
   bit   hold_rsp;
   int   hold_cnt;

   logic [AXIS_POINTS-1:0][VAL_W-1:0] load_pts;
   logic [AXIS_POINTS-1:0][VAL_W-1:0] trans_pts;

   nti_req_if req_chan ();
   nti_rsp_if rsp_chan ();

   nldm_table_bilinear_interp_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   nti_interp_checker scoreboard (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_chan),
      .rsp_mon            (rsp_chan),
      .mismatch_count     (fails),
      .lookups_outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL nldm_table_bilinear_interp_unit");
         $finish;
      end
   end

   // response side: random stalls, calm stretches and repeated long hold-offs
   initial begin
      rsp_chan.ready <= 1'b0;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_cnt = 700;
            hold_rsp = 0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_chan.ready <= 1'b0;
         end else if (calm) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= 38);
         end
      end
   end

   task automatic send(input logic [1:0] typ, input logic [1:0] gate, input logic [1:0] tk,
                       input logic rise, input logic [2:0] row, input logic [2:0] col,
                       input logic [VAL_W-1:0] wv, input logic [VAL_W-1:0] ld,
                       input logic [VAL_W-1:0] tr);
      while (!calm && $urandom_range(99) < 38) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.req_type         <= typ;
      req_chan.gate_kind        <= gate;
      req_chan.table_kind       <= tk;
      req_chan.rise_sel         <= rise;
      req_chan.row_index        <= row;
      req_chan.col_index        <= col;
      req_chan.write_value      <= wv;
      req_chan.load_value       <= ld;
      req_chan.transition_value <= tr;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic query(input logic [1:0] gate, input logic [1:0] tk, input logic rise,
                        input logic [VAL_W-1:0] ld, input logic [VAL_W-1:0] tr);
      send(REQ_QUERY, gate, tk, rise, 3'($urandom), 3'($urandom), VAL_W'($urandom), ld, tr);
   endtask

   task automatic write_cell(input int gate, input int tk, input int rise, input int row,
                             input int col, input logic [VAL_W-1:0] wv);
      send(REQ_WR_TABLE, gate[1:0], tk[1:0], rise[0], row[2:0], col[2:0], wv,
           VAL_W'($urandom), VAL_W'($urandom));
   endtask

   // scheme 0 ascending, 1 equal first pair, 2 equal last pair, 3 descending, 4 random
   function automatic logic [AXIS_POINTS-1:0][VAL_W-1:0] make_axis(input int scheme);
      logic [AXIS_POINTS-1:0][VAL_W-1:0] a;
      logic [AXIS_POINTS-1:0][VAL_W-1:0] r;
      a[0] = VAL_W'($urandom_range(2000));
      for (int i = 1; i < AXIS_POINTS; i++)
         a[i] = a[i-1] + VAL_W'($urandom_range(2_200_000, 1));
      if (scheme == 1) a[1] = a[0];
      if (scheme == 2) a[AXIS_POINTS-2] = a[AXIS_POINTS-1];
      r = a;
      for (int i = 0; i < AXIS_POINTS; i++) begin
         if (scheme == 3) r[i] = a[AXIS_POINTS-1-i];
         if (scheme == 4) r[i] = VAL_W'($urandom);
      end
      return r;
   endfunction

   task automatic load_axes(input int ls, input int ts);
      load_pts  = make_axis(ls);
      trans_pts = make_axis(ts);
      for (int i = 0; i < AXIS_POINTS; i++) begin
         send(REQ_WR_LOAD, 2'($urandom), 2'($urandom), 1'($urandom), i[2:0], 3'($urandom),
              load_pts[i], VAL_W'($urandom), VAL_W'($urandom));
         send(REQ_WR_TRANS, 2'($urandom), 2'($urandom), 1'($urandom), i[2:0], 3'($urandom),
              trans_pts[i], VAL_W'($urandom), VAL_W'($urandom));
      end
   endtask

   function automatic logic [VAL_W-1:0] pick_operand(
         input logic [AXIS_POINTS-1:0][VAL_W-1:0] pts);
      int               r;
      logic [VAL_W-1:0] lo, hi, p;
      r  = $urandom_range(99);
      lo = pts[0];
      hi = pts[0];
      foreach (pts[i]) begin
         if (pts[i] < lo) lo = pts[i];
         if (pts[i] > hi) hi = pts[i];
      end
      p = pts[$urandom_range(AXIS_POINTS-1)];
      if (r < 20) return p;
      if (r < 30) return p + VAL_W'($urandom_range(2)) - VAL_W'(1);
      if (r < 85) return VAL_W'($urandom_range(hi, lo));
      if (r < 90) return (r & 1) ? '1 : '0;
      return VAL_W'($urandom);
   endfunction

   initial begin
      logic [VAL_W-1:0] top_pt;
      int               r;
      reset          <= 1'b1;
      calm           = 0;
      hold_rsp       = 0;
      items_sent     = 0;
      req_chan.valid            <= 1'b0;
      req_chan.req_type         <= REQ_WR_LOAD;
      req_chan.gate_kind        <= '0;
      req_chan.table_kind       <= '0;
      req_chan.rise_sel         <= 1'b0;
      req_chan.row_index        <= '0;
      req_chan.col_index        <= '0;
      req_chan.write_value      <= '0;
      req_chan.load_value       <= '0;
      req_chan.transition_value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill axes and every table before any lookup touches them
      load_axes(0, 0);
      for (int g = 0; g < 3; g++)
         for (int t = 0; t < 3; t++)
            for (int s = 0; s < 2; s++)
               for (int i = 0; i < TABLE_SIZE; i++)
                  write_cell((g == 2 && i[0]) ? 3 : g, t, s, i / AXIS_POINTS,
                             i % AXIS_POINTS, VAL_W'($urandom));

      // directed: edges, exact hits, extrapolation, saturation, negative, ignored writes
      top_pt = load_pts[AXIS_POINTS-1];
      write_cell(0, 0, 1, 6, 5, 24'h000000);
      write_cell(0, 0, 1, 6, 6, 24'hFFFFFF);
      query(0, 0, 1, '1, '1);
      write_cell(0, 0, 1, 6, 5, 24'hFFFFFF);
      write_cell(0, 0, 1, 6, 6, 24'h000000);
      query(0, 0, 1, '1, '1);
      query(0, 0, 1, top_pt, trans_pts[AXIS_POINTS-1]);
      query(1, 1, 0, '0, '0);
      query(2, 2, 1, load_pts[0], trans_pts[0]);
      query(3, 1, 1, load_pts[3], trans_pts[2]);
      query(1, 2, 0, load_pts[2] + VAL_W'(1), trans_pts[4] - VAL_W'(1));
      query(2, 0, 0, VAL_W'((load_pts[1] + load_pts[2]) / 2),
            VAL_W'((trans_pts[5] + trans_pts[6]) / 2));
      query(0, TKIND_NONE, 1, '1, '1);
      send(REQ_WR_TABLE, 2'd1, TKIND_NONE, 1'b1, 3'd2, 3'd2, '1, '0, '0);
      send(REQ_WR_TABLE, 2'd1, 2'd1, 1'b1, 3'd7, 3'd2, '1, '0, '0);
      send(REQ_WR_TABLE, 2'd1, 2'd1, 1'b1, 3'd2, 3'd7, '1, '0, '0);
      send(REQ_WR_LOAD, 2'd0, 2'd0, 1'b0, 3'd7, 3'd0, '1, '0, '0);
      send(REQ_WR_TRANS, 2'd0, 2'd0, 1'b0, 3'd7, 3'd0, '1, '0, '0);
      query(1, 1, 1, load_pts[6], trans_pts[3]);
      query(0, 2, 0, 24'h000001, 24'h800000);

      // random traffic; axis shapes change every so often
      while (items_sent < ITEM_TARGET) begin
         calm = (items_sent >= 1150 && items_sent < 1300);
         if (items_sent % 120 == 0) begin
            r = $urandom_range(9);
            load_axes(r < 5 ? 0 : r - 4, $urandom_range(4) == 0 ? $urandom_range(4) : 0);
         end
         if (items_sent % 200 == 100) begin
            // send four queries into a long response stall, then idle the request side until all results return
            hold_rsp = 1;
            repeat (4) query(2'($urandom), 2'($urandom_range(2)), 1'($urandom),
                             pick_operand(load_pts), pick_operand(trans_pts));
            req_chan.valid <= 1'b0;
            @(posedge clock);
            wait (outstanding == 0);
         end
         r = $urandom_range(99);
         if (r < 72)
            query(2'($urandom),
                  ($urandom_range(19) == 0) ? TKIND_NONE : 2'($urandom_range(2)),
                  1'($urandom), pick_operand(load_pts), pick_operand(trans_pts));
         else if (r < 88)
            write_cell($urandom_range(3), $urandom_range(2), $urandom_range(1),
                       $urandom_range(6), $urandom_range(6), VAL_W'($urandom));
         else if (r < 92) begin
            r = $urandom_range(6);
            top_pt = VAL_W'($urandom);
            load_pts[r] = top_pt;
            send(REQ_WR_LOAD, 2'($urandom), 2'($urandom), 1'($urandom), r[2:0], 3'($urandom),
                 top_pt, VAL_W'($urandom), VAL_W'($urandom));
         end else if (r < 96) begin
            r = $urandom_range(6);
            top_pt = VAL_W'($urandom);
            trans_pts[r] = top_pt;
            send(REQ_WR_TRANS, 2'($urandom), 2'($urandom), 1'($urandom), r[2:0],
                 3'($urandom), top_pt, VAL_W'($urandom), VAL_W'($urandom));
         end else
            send(REQ_WR_TABLE, 2'($urandom), TKIND_NONE, 1'($urandom), 3'($urandom),
                 3'($urandom), VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
      end
      req_chan.valid <= 1'b0;
      calm = 0;
      @(posedge clock);

      wait (outstanding == 0);
      repeat (400) @(posedge clock);
      if (fails == 0 && outstanding == 0)
         $display("PASS nldm_table_bilinear_interp_unit");
      else
         $display("FAIL nldm_table_bilinear_interp_unit");
      $finish;
   end
endmodule
